[sv/strided_4d_address_generator_macros.svh]
// Assertion macros shared by the strided address generator modules.
// Define ASSERT_OFF to compile the assertions away; no other dependencies.
`ifndef STRIDED_4D_ADDRESS_GENERATOR_MACROS_SVH
`define STRIDED_4D_ADDRESS_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define S4AG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define S4AG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define S4AG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define S4AG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/s4ag_pkg.sv]
// Shared types and constants for the four-level strided address generator.
// No dependencies; imported by the top module, the register file, the walker and the testbench.
package s4ag_pkg;

  // Number of nested levels in the walk.
  localparam int NUM_LEVELS = 4;

  // Level positions inside the per-level arrays.
  localparam int LVL_UNIT  = 0;
  localparam int LVL_SLICE = 1;
  localparam int LVL_PLANE = 2;
  localparam int LVL_CUBE  = 3;

  // Request codes carried by the mode field.
  localparam logic MODE_NEXT    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Configuration register map, in word order.
  typedef enum logic [2:0] {
    REG_UNIT_COUNT,
    REG_SLICE_COUNT,
    REG_PLANE_COUNT,
    REG_CUBE_COUNT,
    REG_UNIT_STRIDE,
    REG_SLICE_STRIDE,
    REG_PLANE_STRIDE,
    REG_CUBE_STRIDE
  } reg_idx_t;

  // Status flags that travel with each generated point.
  typedef struct packed {
    logic end_of_slice;
    logic end_of_plane;
    logic end_of_cube;
    logic end_of_tensor;
    logic point_valid;
  } end_flags_t;

endpackage

[sv/strided_4d_address_generator.sv]
// Four-level strided address generator: one address per accepted request, walking
// units within slices within planes within cubes. A request with mode = 1 restarts
// the walk at base_address; mode = 0 yields the next point with its per-level
// indices and end-of-level flags, and point_valid = 0 once the walk is done. The
// block accepts one request per clock unless stalled; each result is loaded into
// the output register in the cycle after its request is accepted, and the input
// stalls only while the output side stalls a held result. The walker's counter
// compare and stride add logic forms the next point combinationally. The user must
// write counts and strides via APB only while idle; the block does not enforce it.
module strided_4d_address_generator #(
  parameter int MAX_LEVEL_COUNT = 1024,
  parameter int ADDR_WIDTH      = 22,
  localparam int IDX_W   = $clog2(MAX_LEVEL_COUNT),
  localparam int CNT_W   = IDX_W + 1,
  localparam int DATA_W  = (ADDR_WIDTH > 32) ? 64 : 32,
  localparam int PADDR_W = (DATA_W > 32) ? 6 : 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [ADDR_WIDTH-1:0] in_base_address,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADDR_WIDTH-1:0] out_address,
  output logic [IDX_W-1:0]      out_unit_index,
  output logic [IDX_W-1:0]      out_slice_index,
  output logic [IDX_W-1:0]      out_plane_index,
  output logic [IDX_W-1:0]      out_cube_index,
  output logic                  out_end_of_slice,
  output logic                  out_end_of_plane,
  output logic                  out_end_of_cube,
  output logic                  out_end_of_tensor,
  output logic                  out_point_valid,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);
  import s4ag_pkg::*;

  localparam int FLAGS_W = $bits(end_flags_t);
  localparam int PAY_W   = ADDR_WIDTH + NUM_LEVELS * IDX_W + FLAGS_W;

  logic [NUM_LEVELS-1:0][CNT_W-1:0]      counts;
  logic [NUM_LEVELS-1:0][ADDR_WIDTH-1:0] strides;
  logic [ADDR_WIDTH-1:0]                 res_address;
  logic [NUM_LEVELS-1:0][IDX_W-1:0]      res_index;
  end_flags_t                            res_flags;
  logic                                  fire;
  logic [PAY_W-1:0]                      pay_in, pay_out;
  logic [ADDR_WIDTH-1:0]                 pay_address;
  logic [NUM_LEVELS-1:0][IDX_W-1:0]      pay_index;
  end_flags_t                            pay_flags;

  assign fire = in_valid && !in_stall;

  s4ag_cfg_regs #(
    .CNT_W   (CNT_W),
    .ADDR_W  (ADDR_WIDTH),
    .DATA_W  (DATA_W),
    .PADDR_W (PADDR_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .counts  (counts),
    .strides (strides)
  );

  s4ag_walker #(
    .MAX_LEVEL_COUNT (MAX_LEVEL_COUNT),
    .IDX_W           (IDX_W),
    .CNT_W           (CNT_W),
    .ADDR_W          (ADDR_WIDTH)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .mode         (in_mode),
    .base_address (in_base_address),
    .counts       (counts),
    .strides      (strides),
    .res_address  (res_address),
    .res_index    (res_index),
    .res_flags    (res_flags)
  );

  // Pack the result for the output register.
  assign pay_in = {res_address, res_index, res_flags};

  s4ag_out_reg #(
    .WIDTH (PAY_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .data_in    (pay_in),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .data_out   (pay_out),
    .full_stall (in_stall)
  );

  // Unpack the registered result onto the output ports.
  assign {pay_address, pay_index, pay_flags} = pay_out;

  assign out_address       = pay_address;
  assign out_unit_index    = pay_index[LVL_UNIT];
  assign out_slice_index   = pay_index[LVL_SLICE];
  assign out_plane_index   = pay_index[LVL_PLANE];
  assign out_cube_index    = pay_index[LVL_CUBE];
  assign out_end_of_slice  = pay_flags.end_of_slice;
  assign out_end_of_plane  = pay_flags.end_of_plane;
  assign out_end_of_cube   = pay_flags.end_of_cube;
  assign out_end_of_tensor = pay_flags.end_of_tensor;
  assign out_point_valid   = pay_flags.point_valid;

endmodule

[sv/s4ag_cfg_regs.sv]
// APB register file holding the level counts and strides.
// Depends on s4ag_pkg for the register map.
module s4ag_cfg_regs #(
  parameter int CNT_W    = 11,
  parameter int ADDR_W   = 22,
  parameter int DATA_W   = 32,
  parameter int PADDR_W  = 5
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [PADDR_W-1:0]                       paddr,
  input  logic [DATA_W-1:0]                        pwdata,
  output logic [DATA_W-1:0]                        prdata,
  output logic                                     pready,
  output logic [s4ag_pkg::NUM_LEVELS-1:0][CNT_W-1:0]  counts,
  output logic [s4ag_pkg::NUM_LEVELS-1:0][ADDR_W-1:0] strides
);
  import s4ag_pkg::*;

  localparam int WORD_LSB = PADDR_W - 3;

  logic [NUM_LEVELS-1:0][CNT_W-1:0]  count_r;
  logic [NUM_LEVELS-1:0][ADDR_W-1:0] stride_r;
  logic                              wr_en;
  reg_idx_t                          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:WORD_LSB]);

  // Register writes; counts reset to one, unit stride to one, others to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count_r[i]  <= CNT_W'(1);
        stride_r[i] <= '0;
      end
      stride_r[LVL_UNIT] <= ADDR_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_UNIT_COUNT:   count_r[LVL_UNIT]   <= pwdata[CNT_W-1:0];
        REG_SLICE_COUNT:  count_r[LVL_SLICE]  <= pwdata[CNT_W-1:0];
        REG_PLANE_COUNT:  count_r[LVL_PLANE]  <= pwdata[CNT_W-1:0];
        REG_CUBE_COUNT:   count_r[LVL_CUBE]   <= pwdata[CNT_W-1:0];
        REG_UNIT_STRIDE:  stride_r[LVL_UNIT]  <= pwdata[ADDR_W-1:0];
        REG_SLICE_STRIDE: stride_r[LVL_SLICE] <= pwdata[ADDR_W-1:0];
        REG_PLANE_STRIDE: stride_r[LVL_PLANE] <= pwdata[ADDR_W-1:0];
        REG_CUBE_STRIDE:  stride_r[LVL_CUBE]  <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer, zero-extended to the bus width.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_UNIT_COUNT:   prdata = DATA_W'(count_r[LVL_UNIT]);
      REG_SLICE_COUNT:  prdata = DATA_W'(count_r[LVL_SLICE]);
      REG_PLANE_COUNT:  prdata = DATA_W'(count_r[LVL_PLANE]);
      REG_CUBE_COUNT:   prdata = DATA_W'(count_r[LVL_CUBE]);
      REG_UNIT_STRIDE:  prdata = DATA_W'(stride_r[LVL_UNIT]);
      REG_SLICE_STRIDE: prdata = DATA_W'(stride_r[LVL_SLICE]);
      REG_PLANE_STRIDE: prdata = DATA_W'(stride_r[LVL_PLANE]);
      REG_CUBE_STRIDE:  prdata = DATA_W'(stride_r[LVL_CUBE]);
      default:          prdata = '0;
    endcase
  end

  assign counts  = count_r;
  assign strides = stride_r;

endmodule

[sv/s4ag_walker.sv]
// Walk state and single-pass next-point logic for the strided generator.
// Depends on s4ag_pkg and the assertion macro header.
`include "strided_4d_address_generator_macros.svh"

module s4ag_walker #(
  parameter int MAX_LEVEL_COUNT = 1024,
  parameter int IDX_W           = 10,
  parameter int CNT_W           = 11,
  parameter int ADDR_W          = 22
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        fire,
  input  logic                                        mode,
  input  logic [ADDR_W-1:0]                           base_address,
  input  logic [s4ag_pkg::NUM_LEVELS-1:0][CNT_W-1:0]  counts,
  input  logic [s4ag_pkg::NUM_LEVELS-1:0][ADDR_W-1:0] strides,
  output logic [ADDR_W-1:0]                           res_address,
  output logic [s4ag_pkg::NUM_LEVELS-1:0][IDX_W-1:0]  res_index,
  output s4ag_pkg::end_flags_t                        res_flags
);
  import s4ag_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LEVEL_COUNT);
  localparam logic [CNT_W-1:0] MAX_LAST = CNT_W'(MAX_LEVEL_COUNT - 1);

  // Counters carry a sticky top bit: set once a counter has gone past the index
  // range, so that it keeps reading as being at the end of its level.
  logic [NUM_LEVELS-1:0][CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] cur_addr_r, cur_addr_nxt;
  logic [ADDR_W-1:0] slice_start_r, slice_start_nxt;
  logic [ADDR_W-1:0] plane_start_r, plane_start_nxt;
  logic [ADDR_W-1:0] cube_start_r, cube_start_nxt;
  logic              finished_r, finished_nxt;

  logic [NUM_LEVELS-1:0][CNT_W-1:0] last_idx;
  logic [NUM_LEVELS-1:0]            end_cur;
  logic [NUM_LEVELS-1:0]            end_nxt;
  logic                             point_ok;
  logic                             tensor_done;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    logic [IDX_W-1:0] low;
    low = c[IDX_W-1:0];
    return {c[CNT_W-1] | (&low), low + IDX_W'(1)};
  endfunction

  // Last valid index per level, with zero read as one and large counts clamped.
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (counts[i] == '0) begin
        last_idx[i] = '0;
      end else if (counts[i] > MAX_CNT) begin
        last_idx[i] = MAX_LAST;
      end else begin
        last_idx[i] = counts[i] - CNT_W'(1);
      end
      end_cur[i] = cnt_r[i] >= last_idx[i];
    end
  end

  // Advance the walk: restart, hold when finished, or step the lowest level
  // that is not yet at its end.
  always_comb begin
    cnt_nxt         = cnt_r;
    cur_addr_nxt    = cur_addr_r;
    slice_start_nxt = slice_start_r;
    plane_start_nxt = plane_start_r;
    cube_start_nxt  = cube_start_r;
    point_ok        = 1'b1;
    if (mode == MODE_RESTART) begin
      cnt_nxt         = '0;
      cur_addr_nxt    = base_address;
      slice_start_nxt = base_address;
      plane_start_nxt = base_address;
      cube_start_nxt  = base_address;
    end else if (finished_r) begin
      point_ok = 1'b0;
    end else if (!end_cur[LVL_UNIT]) begin
      cnt_nxt[LVL_UNIT] = cnt_inc(cnt_r[LVL_UNIT]);
      cur_addr_nxt      = cur_addr_r + strides[LVL_UNIT];
    end else if (!end_cur[LVL_SLICE]) begin
      cnt_nxt[LVL_UNIT]  = '0;
      cnt_nxt[LVL_SLICE] = cnt_inc(cnt_r[LVL_SLICE]);
      slice_start_nxt    = slice_start_r + strides[LVL_SLICE];
      cur_addr_nxt       = slice_start_nxt;
    end else if (!end_cur[LVL_PLANE]) begin
      cnt_nxt[LVL_UNIT]  = '0;
      cnt_nxt[LVL_SLICE] = '0;
      cnt_nxt[LVL_PLANE] = cnt_inc(cnt_r[LVL_PLANE]);
      plane_start_nxt    = plane_start_r + strides[LVL_PLANE];
      slice_start_nxt    = plane_start_nxt;
      cur_addr_nxt       = plane_start_nxt;
    end else begin
      cnt_nxt[LVL_UNIT]  = '0;
      cnt_nxt[LVL_SLICE] = '0;
      cnt_nxt[LVL_PLANE] = '0;
      cnt_nxt[LVL_CUBE]  = cnt_inc(cnt_r[LVL_CUBE]);
      cube_start_nxt     = cube_start_r + strides[LVL_CUBE];
      plane_start_nxt    = cube_start_nxt;
      slice_start_nxt    = cube_start_nxt;
      cur_addr_nxt       = cube_start_nxt;
    end
  end

  // End-of-level flags of the point being produced.
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      end_nxt[i] = cnt_nxt[i] >= last_idx[i];
    end
  end

  assign tensor_done = point_ok && (&end_nxt);

  // Result fields come from the updated state; a request after the end reads zero.
  always_comb begin
    finished_nxt = finished_r;
    if (mode == MODE_RESTART) begin
      finished_nxt = 1'b0;
    end
    if (tensor_done) begin
      finished_nxt = 1'b1;
    end
    res_address = '0;
    res_index   = '0;
    res_flags   = '0;
    if (point_ok) begin
      res_address = cur_addr_nxt;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        res_index[i] = cnt_nxt[i][IDX_W-1:0];
      end
      res_flags.end_of_slice  = end_nxt[LVL_UNIT];
      res_flags.end_of_plane  = end_nxt[LVL_UNIT] && end_nxt[LVL_SLICE];
      res_flags.end_of_cube   = end_nxt[LVL_UNIT] && end_nxt[LVL_SLICE] &&
                                end_nxt[LVL_PLANE];
      res_flags.end_of_tensor = tensor_done;
      res_flags.point_valid   = 1'b1;
    end
  end

  // Walk state registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      cur_addr_r    <= '0;
      slice_start_r <= '0;
      plane_start_r <= '0;
      cube_start_r  <= '0;
      finished_r    <= 1'b1;
    end else if (fire) begin
      cnt_r         <= cnt_nxt;
      cur_addr_r    <= cur_addr_nxt;
      slice_start_r <= slice_start_nxt;
      plane_start_r <= plane_start_nxt;
      cube_start_r  <= cube_start_nxt;
      finished_r    <= finished_nxt;
    end
  end

  // The final point of a walk closes it for the following request.
  `S4AG_ASSERT_NEXT(a_done_closes_walk, clk, rst_n,
    fire && res_flags.end_of_tensor, finished_r, "walk not closed after final point")

  // A request on a closed walk leaves the position untouched.
  `S4AG_ASSERT_NEXT(a_closed_walk_holds, clk, rst_n,
    fire && finished_r && (mode == MODE_NEXT),
    $stable(cur_addr_r) && $stable(cnt_r), "closed walk changed its position")

  // A restart puts the walk at its base with all counters cleared.
  `S4AG_ASSERT_NEXT(a_restart_loads_base, clk, rst_n,
    fire && (mode == MODE_RESTART),
    (cur_addr_r == $past(base_address)) && (cnt_r == '0),
    "restart did not load the base address")

endmodule

[sv/s4ag_out_reg.sv]
// Result register between the walk logic and the output channel.
// Depends on the assertion macro header only.
`include "strided_4d_address_generator_macros.svh"

module s4ag_out_reg #(
  parameter int WIDTH = 67
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [WIDTH-1:0] data_in,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [WIDTH-1:0] data_out,
  output logic             full_stall
);

  logic             valid_r, valid_nxt;
  logic [WIDTH-1:0] data_r;

  // A held result blocks new loads only while the consumer stalls it.
  assign full_stall = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_in;
    end
  end

  assign out_valid = valid_r;
  assign data_out  = data_r;

  // A load must never overwrite a result that the consumer still stalls.
  `S4AG_ASSERT_IMPLY(a_no_overwrite, clk, rst_n,
    load, !full_stall, "result overwritten while stalled")

  // Every load shows up as a valid result in the next cycle.
  `S4AG_ASSERT_NEXT(a_load_shows, clk, rst_n,
    load, valid_r && (data_r == $past(data_in)), "loaded result not presented")

endmodule

[tb/tb_strided_4d_address_generator.sv]
// Self-checking testbench for the four-level strided address generator.
// Depends on s4ag_pkg and strided_4d_address_generator; needs no files or arguments.
module tb_strided_4d_address_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import s4ag_pkg::*;

  localparam int AW          = 22;
  localparam int IW          = 10;
  localparam int MAX_CNT     = 1024;
  localparam int ITEM_TARGET = 1700;

  typedef struct {
    logic          mode;
    logic [AW-1:0] base;
  } request_t;

  typedef struct packed {
    logic [AW-1:0] address;
    logic [IW-1:0] unit_index;
    logic [IW-1:0] slice_index;
    logic [IW-1:0] plane_index;
    logic [IW-1:0] cube_index;
    end_flags_t    flags;
  } point_t;

  // Clock, reset and block ports.
  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_mode = MODE_NEXT;
  logic [AW-1:0] in_base_address = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [AW-1:0] out_address;
  logic [IW-1:0] out_unit_index;
  logic [IW-1:0] out_slice_index;
  logic [IW-1:0] out_plane_index;
  logic [IW-1:0] out_cube_index;
  logic          out_end_of_slice;
  logic          out_end_of_plane;
  logic          out_end_of_cube;
  logic          out_end_of_tensor;
  logic          out_point_valid;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Request items waiting to be driven and points expected from the block.
  request_t request_q[$];
  point_t   point_q[$];
  request_t cur_req;
  point_t   exp_pt;
  point_t   act_pt;
  int       errors = 0;
  int       items_queued = 0;

  // Idle control: a rate of zero means no idling on that side.
  int send_idle_rate = 0;
  int recv_idle_rate = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // Shadow copy of the configuration and of the walker state.
  logic [10:0]   cfg_count[4];
  logic [AW-1:0] cfg_stride[4];
  logic [IW-1:0] ctr[4];
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] slice_base;
  logic [AW-1:0] plane_base;
  logic [AW-1:0] cube_base;
  logic          walk_done;

  strided_4d_address_generator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_base_address   (in_base_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_address       (out_address),
    .out_unit_index    (out_unit_index),
    .out_slice_index   (out_slice_index),
    .out_plane_index   (out_plane_index),
    .out_cube_index    (out_cube_index),
    .out_end_of_slice  (out_end_of_slice),
    .out_end_of_plane  (out_end_of_plane),
    .out_end_of_cube   (out_end_of_cube),
    .out_end_of_tensor (out_end_of_tensor),
    .out_point_valid   (out_point_valid),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A count of zero acts as one; counts above the maximum saturate.
  function automatic logic [10:0] eff_count(int lvl);
    if (cfg_count[lvl] == 11'd0) return 11'd1;
    if (cfg_count[lvl] > MAX_CNT) return 11'(MAX_CNT);
    return cfg_count[lvl];
  endfunction

  // A counter at or past its count minus one is at the end of its level.
  function automatic logic level_done(int lvl);
    return {1'b0, ctr[lvl]} >= eff_count(lvl) - 11'd1;
  endfunction

  function automatic longint walk_length();
    return longint'(eff_count(LVL_UNIT)) * longint'(eff_count(LVL_SLICE)) *
           longint'(eff_count(LVL_PLANE)) * longint'(eff_count(LVL_CUBE));
  endfunction

  // Advance the shadow walker by one request and return the point it yields.
  function automatic point_t step_walker(request_t r);
    point_t p;
    int     i;
    p = '0;
    if (r.mode != MODE_RESTART && walk_done) return p;
    if (r.mode == MODE_RESTART) begin
      for (i = 0; i < NUM_LEVELS; i++) ctr[i] = '0;
      cur_addr   = r.base;
      slice_base = r.base;
      plane_base = r.base;
      cube_base  = r.base;
      walk_done  = 1'b0;
    end else if (!level_done(LVL_UNIT)) begin
      ctr[LVL_UNIT]++;
      cur_addr = cur_addr + cfg_stride[LVL_UNIT];
    end else if (!level_done(LVL_SLICE)) begin
      ctr[LVL_UNIT] = '0;
      ctr[LVL_SLICE]++;
      slice_base = slice_base + cfg_stride[LVL_SLICE];
      cur_addr   = slice_base;
    end else if (!level_done(LVL_PLANE)) begin
      ctr[LVL_UNIT]  = '0;
      ctr[LVL_SLICE] = '0;
      ctr[LVL_PLANE]++;
      plane_base = plane_base + cfg_stride[LVL_PLANE];
      slice_base = plane_base;
      cur_addr   = plane_base;
    end else begin
      ctr[LVL_UNIT]  = '0;
      ctr[LVL_SLICE] = '0;
      ctr[LVL_PLANE] = '0;
      ctr[LVL_CUBE]++;
      cube_base  = cube_base + cfg_stride[LVL_CUBE];
      plane_base = cube_base;
      slice_base = cube_base;
      cur_addr   = cube_base;
    end
    p.address             = cur_addr;
    p.unit_index          = ctr[LVL_UNIT];
    p.slice_index         = ctr[LVL_SLICE];
    p.plane_index         = ctr[LVL_PLANE];
    p.cube_index          = ctr[LVL_CUBE];
    p.flags.end_of_slice  = level_done(LVL_UNIT);
    p.flags.end_of_plane  = p.flags.end_of_slice && level_done(LVL_SLICE);
    p.flags.end_of_cube   = p.flags.end_of_plane && level_done(LVL_PLANE);
    p.flags.end_of_tensor = p.flags.end_of_cube && level_done(LVL_CUBE);
    p.flags.point_valid   = 1'b1;
    if (p.flags.end_of_tensor) walk_done = 1'b1;
    return p;
  endfunction

  // Request driver: a new transaction is presented only when none is pending.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) point_q.push_back(step_walker(cur_req));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (send_idle_rate != 0 && $urandom_range(0, send_idle_rate - 1) == 0) begin
          send_gap = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= cur_req.mode;
          in_base_address <= cur_req.base;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest expected point.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        act_pt = {out_address, out_unit_index, out_slice_index, out_plane_index,
                  out_cube_index, out_end_of_slice, out_end_of_plane, out_end_of_cube,
                  out_end_of_tensor, out_point_valid};
        if (point_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: addr=%h idx=%0d/%0d/%0d/%0d flags=%b",
                     act_pt.address, act_pt.unit_index, act_pt.slice_index,
                     act_pt.plane_index, act_pt.cube_index, act_pt.flags);
          errors++;
        end else begin
          exp_pt = point_q.pop_front();
          if (act_pt !== exp_pt) begin
            if (errors < 10) begin
              $display("mismatch: exp addr=%h idx=%0d/%0d/%0d/%0d flags=%b",
                       exp_pt.address, exp_pt.unit_index, exp_pt.slice_index,
                       exp_pt.plane_index, exp_pt.cube_index, exp_pt.flags);
              $display("          got addr=%h idx=%0d/%0d/%0d/%0d flags=%b",
                       act_pt.address, act_pt.unit_index, act_pt.slice_index,
                       act_pt.plane_index, act_pt.cube_index, act_pt.flags);
            end
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (recv_idle_rate != 0 && $urandom_range(0, recv_idle_rate - 1) == 0) begin
        recv_gap = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // APB write: setup cycle, then access cycle; the shadow copy follows the write.
  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (int'(r) < int'(REG_UNIT_STRIDE)) cfg_count[int'(r)] = v[10:0];
    else cfg_stride[int'(r) - int'(REG_UNIT_STRIDE)] = v[AW-1:0];
  endtask

  task automatic push_req(logic m, logic [AW-1:0] b);
    request_t r;
    r.mode = m;
    r.base = b;
    request_q.push_back(r);
    items_queued++;
  endtask

  // Wait until every queued transaction has gone through and every point has come back.
  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || point_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [10:0] rand_count();
    case ($urandom_range(0, 19))
      0: return 11'd0;
      1: return 11'd2047;
      2: return 11'd1024;
      3: return 11'($urandom_range(5, 40));
      default: return 11'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_addr();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return AW'($urandom());
    endcase
  endfunction

  function automatic int rand_rate();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 32;
    endcase
  endfunction

  // Fill the request queue with restart-led walks plus some stray transactions.
  task automatic fill_random(int count);
    int     n;
    longint len;
    int     nexts;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(logic'($urandom_range(0, 1)), rand_addr());
        n++;
      end else begin
        len = walk_length();
        if (len > 60) nexts = $urandom_range(5, 60);
        else if ($urandom_range(0, 4) == 0) nexts = $urandom_range(0, int'(len));
        else nexts = int'(len) - 1 + int'($urandom_range(0, 3));
        // Occasionally continue the current walk instead of restarting it.
        if ($urandom_range(0, 7) != 0) push_req(MODE_RESTART, rand_addr());
        repeat (nexts) push_req(MODE_NEXT, AW'($urandom()));
        n += nexts + 1;
      end
    end
  endtask

  // Main sequence: reset, directed checks, random phases, calm tail, verdict.
  initial begin
    int i;
    for (i = 0; i < NUM_LEVELS; i++) begin
      cfg_count[i]  = 11'd1;
      cfg_stride[i] = '0;
      ctr[i]        = '0;
    end
    cfg_stride[LVL_UNIT] = 'd1;
    cur_addr   = '0;
    slice_base = '0;
    plane_base = '0;
    cube_base  = '0;
    walk_done  = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset state: nothing to walk, then single-point tensors.
    push_req(MODE_NEXT, '1);
    push_req(MODE_RESTART, '0);
    push_req(MODE_NEXT, '0);
    push_req(MODE_RESTART, '1);
    push_req(MODE_RESTART, 22'h2AAAAA);
    wait_idle();

    // Wrapping strides and a zero count on the plane level.
    write_reg(REG_UNIT_COUNT, 32'd2);
    write_reg(REG_SLICE_COUNT, 32'd2);
    write_reg(REG_PLANE_COUNT, 32'd0);
    write_reg(REG_CUBE_COUNT, 32'd2);
    write_reg(REG_UNIT_STRIDE, 32'h3FFFFF);
    write_reg(REG_SLICE_STRIDE, 32'h155555);
    write_reg(REG_PLANE_STRIDE, 32'h3FFFFF);
    write_reg(REG_CUBE_STRIDE, 32'h2AAAAA);
    @(negedge clk);
    push_req(MODE_RESTART, '1);
    repeat (5) push_req(MODE_NEXT, 22'h155555);
    wait_idle();

    // Saturating count, then a smaller count written in the middle of a walk.
    write_reg(REG_UNIT_COUNT, 32'd2047);
    write_reg(REG_CUBE_COUNT, 32'd1);
    @(negedge clk);
    push_req(MODE_RESTART, 22'h000100);
    repeat (3) push_req(MODE_NEXT, '0);
    wait_idle();
    write_reg(REG_UNIT_COUNT, 32'd2);
    @(negedge clk);
    push_req(MODE_NEXT, '0);
    push_req(MODE_NEXT, '0);
    push_req(MODE_RESTART, 22'h3FFFFE);
    push_req(MODE_NEXT, '0);
    wait_idle();

    // Random phases; each begins idle, so configuration changes are safe.
    while (items_queued < ITEM_TARGET) begin
      send_idle_rate = rand_rate();
      recv_idle_rate = rand_rate();
      for (i = 0; i < 8; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          if (i < int'(REG_UNIT_STRIDE)) write_reg(reg_idx_t'(i), 32'(rand_count()));
          else write_reg(reg_idx_t'(i), 32'(rand_addr()));
        end
      end
      @(negedge clk);
      fill_random($urandom_range(20, 80));
      wait_idle();
    end

    // Calm tail with full throughput on both sides.
    send_idle_rate = 0;
    recv_idle_rate = 0;
    send_gap = 0;
    recv_gap = 0;
    write_reg(REG_UNIT_COUNT, 32'd3);
    write_reg(REG_SLICE_COUNT, 32'd2);
    write_reg(REG_PLANE_COUNT, 32'd2);
    write_reg(REG_CUBE_COUNT, 32'd2);
    @(negedge clk);
    fill_random(120);
    wait_idle();

    repeat (10) @(posedge clk);
    errors += point_q.size();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
